// File: sv/msrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msrc_pkg;

    // Field widths of the transaction payloads and registers.
    localparam int SPEED_W    = 16;
    localparam int COUNT_W    = 24;
    localparam int TIME_W     = 32;
    localparam int STEPS_W    = 8;
    localparam int INTERVAL_W = 16;
    localparam int DIFF_W     = SPEED_W + 1;
    localparam int MAG_W      = SPEED_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Input transaction kinds.
    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_DRIVE = 2'd1,
        MODE_MOVE  = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    // Controller phases, as reported on the result.
    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_UPSTART   = 3'd1,
        PH_UP        = 3'd2,
        PH_RUN       = 3'd3,
        PH_DOWNSTART = 3'd4,
        PH_DOWN      = 3'd5,
        PH_MOVESTART = 3'd6,
        PH_MOVERUN   = 3'd7
    } t_phase;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEPS    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = CFG_IDX_W'(1);

    // Configuration reset values.
    localparam logic [STEPS_W-1:0]    RAMP_STEPS_RST    = STEPS_W'(10);
    localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RST = INTERVAL_W'(100);

    typedef struct packed {
        t_mode                     mode;
        logic [TIME_W-1:0]         now_ms;
        logic                      motor_busy;
        logic signed [SPEED_W-1:0] target_speed;
        logic signed [COUNT_W-1:0] move_count;
    } t_in_item;

    typedef struct packed {
        logic                      velocity_write;
        logic signed [SPEED_W-1:0] velocity_value;
        logic                      start_motor;
        logic                      stop_motor;
        logic                      move_load;
        logic signed [COUNT_W-1:0] move_pulses;
        t_phase                    phase;
    } t_out_item;

endpackage

`default_nettype wire

// File: sv/msrc_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial restoring divider: signed numerator by unsigned nonzero divisor,
// one quotient bit per cycle, truncating toward zero.
module msrc_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [msrc_pkg::DIFF_W-1:0]  i_num,
    input  wire logic [msrc_pkg::STEPS_W-1:0]        i_den,
    output logic                                     o_done,
    output logic signed [msrc_pkg::DIFF_W-1:0]       o_quot
);
    import msrc_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [MAG_W-1:0]      r_mag;
    logic [STEPS_W-1:0]    r_rem;
    logic [STEPS_W-1:0]    r_den;
    logic                  r_neg;

    logic [DIFF_W-1:0]     num_abs;
    logic [STEPS_W:0]      rem_sh;
    logic                  q_bit;
    logic [STEPS_W:0]      rem_sub;

    // Magnitude of the numerator; its range never reaches the most negative code.
    assign num_abs = i_num[DIFF_W-1] ? DIFF_W'(-i_num) : DIFF_W'(i_num);

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign rem_sh  = {r_rem, r_mag[MAG_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_mag  <= num_abs[MAG_W-1:0];
                r_rem  <= '0;
                r_den  <= i_den;
                r_neg  <= i_num[DIFF_W-1];
            end else if (r_busy) begin
                r_mag <= {r_mag[MAG_W-2:0], q_bit};
                r_rem <= q_bit ? rem_sub[STEPS_W-1:0] : rem_sh[STEPS_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Apply the sign to the quotient magnitude.
    assign o_quot = r_neg ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: sv/motor_speed_ramp_controller.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequence: an accepted transaction passes the start, sum and execute states; a tick in a
// ramp-start phase also waits in the divide state for the serial step divider.
// Throughput: one transaction at a time, the next one accepted from the cycle after the
// result is registered; the result register lets the next one in while the
// previous result still waits.
// Reset (synchronous, active low): idle phase, state cleared, registers 10 and 100.
module motor_speed_ramp_controller (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire msrc_pkg::t_in_item                    i_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output msrc_pkg::t_out_item                        o_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [msrc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [msrc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import msrc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_SUM,
        S_EXEC
    } t_state;

    localparam int SUM_W = COUNT_W + 1;

    t_state                    r_state, n_state;
    t_in_item                  r_in;
    t_out_item                 r_out;
    logic                      r_out_valid;
    logic [STEPS_W-1:0]        r_ramp_steps;
    logic [INTERVAL_W-1:0]     r_interval;
    t_phase                    r_phase, n_phase;
    logic signed [SPEED_W-1:0] r_cur, n_cur;
    logic signed [SPEED_W-1:0] r_set, n_set;
    logic signed [COUNT_W-1:0] r_step, n_step;
    logic [TIME_W-1:0]         r_last, n_last;
    logic                      r_elapsed;
    logic signed [SPEED_W-1:0] r_sum;

    t_out_item                 res;
    logic                      need_div;
    logic                      out_free;
    logic [STEPS_W-1:0]        div_den;
    logic signed [DIFF_W-1:0]  div_num;
    logic                      div_done;
    logic signed [DIFF_W-1:0]  div_quot;
    logic signed [COUNT_W-1:0] quot_step;
    logic                      is_up;
    logic signed [SUM_W-1:0]   ext_cur;
    logic signed [SUM_W-1:0]   ext_step;
    logic signed [SUM_W-1:0]   sum_raw;
    logic signed [SPEED_W-1:0] sum_sat;
    logic [TIME_W-1:0]         time_diff;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || i_out_ready;

    // Ramp-start ticks need a fresh step size from the divider.
    assign need_div = (r_in.mode == MODE_TICK) &&
                      ((r_phase == PH_UPSTART) || (r_phase == PH_DOWNSTART));
    assign div_den  = (r_ramp_steps == '0) ? STEPS_W'(1) : r_ramp_steps;
    assign div_num  = (r_phase == PH_UPSTART) ?
                      (DIFF_W'(r_set) - DIFF_W'(r_cur)) :
                      (DIFF_W'(r_cur) - DIFF_W'(r_set));

    msrc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_START && need_div),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // A step that truncates to zero is forced to one.
    assign quot_step = (div_quot == '0) ? COUNT_W'(1) : COUNT_W'(div_quot);

    // Speed plus or minus the step, saturated to the signed speed range.
    assign is_up    = (r_phase == PH_UPSTART) || (r_phase == PH_UP);
    assign ext_cur  = SUM_W'(r_cur);
    assign ext_step = SUM_W'(r_step);
    assign sum_raw  = is_up ? (ext_cur + ext_step) : (ext_cur - ext_step);

    always_comb begin
        if (sum_raw > SUM_W'(32767)) begin
            sum_sat = 16'sh7FFF;
        end else if (sum_raw < -SUM_W'(32768)) begin
            sum_sat = 16'sh8000;
        end else begin
            sum_sat = sum_raw[SPEED_W-1:0];
        end
    end

    // Wrapping time since the last applied step.
    assign time_diff = r_in.now_ms - r_last;

    // Controller update for the held transaction.
    always_comb begin
        n_phase = r_phase;
        n_cur   = r_cur;
        n_set   = r_set;
        n_step  = r_step;
        n_last  = r_last;
        res     = '0;
        case (r_in.mode)
            MODE_DRIVE: begin
                n_set = r_in.target_speed;
                if (r_phase != PH_RUN) begin
                    n_phase = PH_UPSTART;
                end
            end
            MODE_MOVE: begin
                n_set   = r_in.target_speed;
                n_step  = r_in.move_count;
                n_phase = PH_MOVESTART;
            end
            MODE_STOP: begin
                n_cur   = '0;
                n_phase = PH_IDLE;
            end
            default: begin
                case (r_phase)
                    PH_IDLE: begin
                        res.stop_motor = r_in.motor_busy;
                    end
                    PH_UPSTART: begin
                        n_cur              = r_sum;
                        res.velocity_write = 1'b1;
                        res.velocity_value = r_sum;
                        res.start_motor    = 1'b1;
                        n_last             = '0;
                        n_phase            = PH_UP;
                    end
                    PH_UP: begin
                        if (r_elapsed) begin
                            if (r_cur >= r_set) begin
                                n_phase = PH_RUN;
                            end else begin
                                n_cur = (r_sum > r_set) ? r_set : r_sum;
                            end
                            res.velocity_write = 1'b1;
                            res.velocity_value = n_cur;
                            n_last             = r_in.now_ms;
                        end
                    end
                    PH_RUN: begin
                        if (!r_in.motor_busy) begin
                            n_cur   = '0;
                            n_phase = PH_IDLE;
                        end else if (r_cur < r_set) begin
                            n_phase = PH_UPSTART;
                        end else if (r_cur > r_set) begin
                            n_phase = PH_DOWNSTART;
                        end
                    end
                    PH_DOWNSTART: begin
                        n_cur   = r_sum;
                        n_last  = '0;
                        n_phase = PH_DOWN;
                    end
                    PH_DOWN: begin
                        if (r_elapsed) begin
                            res.velocity_write = 1'b1;
                            res.velocity_value = r_cur;
                            n_last             = r_in.now_ms;
                            if (r_cur <= r_set) begin
                                n_phase = (r_set == '0) ? PH_IDLE : PH_RUN;
                            end else begin
                                n_cur = (r_sum < r_set) ? r_set : r_sum;
                            end
                        end
                    end
                    PH_MOVESTART: begin
                        res.velocity_write = 1'b1;
                        res.velocity_value = r_set;
                        res.move_load      = 1'b1;
                        res.move_pulses    = r_step;
                        res.start_motor    = 1'b1;
                        n_phase            = PH_MOVERUN;
                    end
                    default: begin
                        if (!r_in.motor_busy) begin
                            n_phase = PH_IDLE;
                        end
                    end
                endcase
            end
        endcase
        res.phase = n_phase;
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = need_div ? S_DIV : S_SUM;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state, controller state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_ramp_steps <= RAMP_STEPS_RST;
            r_interval   <= RAMP_INTERVAL_RST;
            r_phase      <= PH_IDLE;
            r_cur        <= '0;
            r_set        <= '0;
            r_step       <= '0;
            r_last       <= '0;
        end else begin
            r_state <= n_state;

            // Configuration writes.
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_RAMP_STEPS) begin
                    r_ramp_steps <= i_cfg_data[STEPS_W-1:0];
                end else if (i_cfg_index == CFG_RAMP_INTERVAL) begin
                    r_interval <= i_cfg_data[INTERVAL_W-1:0];
                end
            end

            // Capture the input transaction.
            if (r_state == S_IDLE && i_in_valid) begin
                r_in <= i_in;
            end

            if (r_state == S_START) begin
                r_elapsed <= (time_diff >= TIME_W'(r_interval));
            end

            if (r_state == S_DIV && div_done) begin
                r_step <= quot_step;
            end

            if (r_state == S_SUM) begin
                r_sum <= sum_sat;
            end

            // Commit the update and hand the result to the output register.
            if (r_state == S_EXEC && out_free) begin
                r_phase     <= n_phase;
                r_cur       <= n_cur;
                r_set       <= n_set;
                r_step      <= n_step;
                r_last      <= n_last;
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the single-channel stepper speed ramp controller.
// A behavioral copy of the controller predicts the driver command for every
// accepted transaction, and a checker compares each returned command, field by
// field, against the oldest prediction. Directed sequences cover the idle stop
// strobe, reverse ramps, timer wrap, moves and speed saturation. Random drive
// and move sequences then run under several register settings, with random
// stalls on both channels, and finish with a stretch that has no stalls.
module tb_top;
    import msrc_pkg::*;

    localparam int CLK_HALF    = 6;
    // The slowest transaction is a tick in a ramp-start phase.
    localparam int SETTLE_WAIT = 30;
    localparam int STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(2);

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    motor_speed_ramp_controller u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Controller state and registers as the bench tracks them.
    t_phase                ctl_phase;
    int                    cur_speed;
    int                    set_speed;
    int                    step_or_pulses;
    logic [TIME_W-1:0]     last_step_ms;
    logic [STEPS_W-1:0]    steps_reg;
    logic [INTERVAL_W-1:0] interval_reg;

    t_out_item         driver_cmd_q[$];
    logic [TIME_W-1:0] clock_ms     = '0;
    bit                idling_on    = 1'b1;
    int                calm_items   = 0;
    int                fail_count   = 0;
    int                items_sent   = 0;
    int                cmds_checked = 0;
    int                reg_writes   = 0;
    int                vel_writes   = 0;
    int                move_loads   = 0;
    int                stop_strobes = 0;
    int                quiet_cycles = 0;

    // Clock generation.
    initial begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic int sat_speed(int v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return v;
    endfunction

    // Ramp increment: difference over the step count, truncated, never zero.
    function automatic int ramp_increment(int diff);
        int divisor;
        int q;
        divisor = (steps_reg == '0) ? 1 : int'(steps_reg);
        q = diff / divisor;
        return (q == 0) ? 1 : q;
    endfunction

    // Advances the tracked controller by one transaction and returns the
    // driver command it should produce.
    function automatic t_out_item ramp_controller_step(t_in_item it);
        t_out_item         cmd;
        logic [TIME_W-1:0] since_ms;
        bit                elapsed;
        cmd = '0;
        since_ms = it.now_ms - last_step_ms;
        elapsed = (since_ms >= TIME_W'(interval_reg));
        case (it.mode)
            MODE_DRIVE: begin
                set_speed = int'($signed(it.target_speed));
                if (ctl_phase != PH_RUN) begin
                    ctl_phase = PH_UPSTART;
                end
            end
            MODE_MOVE: begin
                set_speed = int'($signed(it.target_speed));
                step_or_pulses = int'($signed(it.move_count));
                ctl_phase = PH_MOVESTART;
            end
            MODE_STOP: begin
                cur_speed = 0;
                ctl_phase = PH_IDLE;
            end
            default: begin
                case (ctl_phase)
                    PH_IDLE: begin
                        cmd.stop_motor = it.motor_busy;
                    end
                    PH_UPSTART: begin
                        step_or_pulses = ramp_increment(set_speed - cur_speed);
                        cur_speed = sat_speed(cur_speed + step_or_pulses);
                        cmd.velocity_write = 1'b1;
                        cmd.velocity_value = SPEED_W'(cur_speed);
                        cmd.start_motor = 1'b1;
                        last_step_ms = '0;
                        ctl_phase = PH_UP;
                    end
                    PH_UP: begin
                        if (elapsed) begin
                            if (cur_speed >= set_speed) begin
                                ctl_phase = PH_RUN;
                            end else begin
                                cur_speed = sat_speed(cur_speed + step_or_pulses);
                                if (cur_speed > set_speed) begin
                                    cur_speed = set_speed;
                                end
                            end
                            cmd.velocity_write = 1'b1;
                            cmd.velocity_value = SPEED_W'(cur_speed);
                            last_step_ms = it.now_ms;
                        end
                    end
                    PH_RUN: begin
                        if (!it.motor_busy) begin
                            cur_speed = 0;
                            ctl_phase = PH_IDLE;
                        end else if (cur_speed < set_speed) begin
                            ctl_phase = PH_UPSTART;
                        end else if (cur_speed > set_speed) begin
                            ctl_phase = PH_DOWNSTART;
                        end
                    end
                    PH_DOWNSTART: begin
                        step_or_pulses = ramp_increment(cur_speed - set_speed);
                        cur_speed = sat_speed(cur_speed - step_or_pulses);
                        last_step_ms = '0;
                        ctl_phase = PH_DOWN;
                    end
                    PH_DOWN: begin
                        if (elapsed) begin
                            cmd.velocity_write = 1'b1;
                            cmd.velocity_value = SPEED_W'(cur_speed);
                            last_step_ms = it.now_ms;
                            if (cur_speed <= set_speed) begin
                                ctl_phase = (set_speed == 0) ? PH_IDLE : PH_RUN;
                            end else begin
                                cur_speed = sat_speed(cur_speed - step_or_pulses);
                                if (cur_speed < set_speed) begin
                                    cur_speed = set_speed;
                                end
                            end
                        end
                    end
                    PH_MOVESTART: begin
                        cmd.velocity_write = 1'b1;
                        cmd.velocity_value = SPEED_W'(set_speed);
                        cmd.move_load = 1'b1;
                        cmd.move_pulses = COUNT_W'(step_or_pulses);
                        cmd.start_motor = 1'b1;
                        ctl_phase = PH_MOVERUN;
                    end
                    default: begin
                        if (!it.motor_busy) begin
                            ctl_phase = PH_IDLE;
                        end
                    end
                endcase
            end
        endcase
        cmd.phase = ctl_phase;
        return cmd;
    endfunction

    function automatic t_in_item make_item(t_mode m, logic [TIME_W-1:0] now, bit busy,
                                           logic [SPEED_W-1:0] tgt,
                                           logic [COUNT_W-1:0] cnt);
        t_in_item it;
        it.mode = m;
        it.now_ms = now;
        it.motor_busy = busy;
        it.target_speed = tgt;
        it.move_count = cnt;
        return it;
    endfunction

    // Speeds lean toward the extremes, zero and small values.
    function automatic logic [SPEED_W-1:0] pick_speed();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3: return SPEED_W'($urandom_range(1, 300));
            4: return SPEED_W'(-int'($urandom_range(1, 300)));
            default: return SPEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    // Millisecond time moves forward by up to about one interval per tick,
    // with an occasional jump anywhere.
    function automatic logic [TIME_W-1:0] next_now();
        if ($urandom_range(0, 24) == 0) begin
            clock_ms = $urandom;
        end else begin
            clock_ms = clock_ms + $urandom_range(0, int'(interval_reg) + 4);
        end
        return clock_ms;
    endfunction

    // Sends one transaction, with an occasional idle gap before it, and
    // records the predicted command once it is accepted.
    task automatic send_item(input t_in_item it);
        t_out_item cmd;
        if (calm_items > 0) begin
            calm_items--;
        end else if ($urandom_range(0, 29) == 0) begin
            calm_items = $urandom_range(20, 60);
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cmd = ramp_controller_step(it);
        driver_cmd_q.push_back(cmd);
        items_sent++;
        vel_writes += cmd.velocity_write;
        move_loads += cmd.move_load;
        stop_strobes += cmd.stop_motor;
    endtask

    task automatic send_tick(input logic [TIME_W-1:0] now, input bit busy);
        send_item(make_item(MODE_TICK, now, busy, SPEED_W'($urandom), COUNT_W'($urandom)));
    endtask

    task automatic send_drive(input logic [SPEED_W-1:0] tgt);
        send_item(make_item(MODE_DRIVE, $urandom, $urandom_range(0, 1), tgt,
                            COUNT_W'($urandom)));
    endtask

    task automatic send_move(input logic [SPEED_W-1:0] tgt, input logic [COUNT_W-1:0] cnt);
        send_item(make_item(MODE_MOVE, $urandom, $urandom_range(0, 1), tgt, cnt));
    endtask

    task automatic send_stop();
        send_item(make_item(MODE_STOP, $urandom, $urandom_range(0, 1), SPEED_W'($urandom),
                            COUNT_W'($urandom)));
    endtask

    // Holds the input back until every predicted command has come back.
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        while (driver_cmd_q.size() != 0) @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_RAMP_STEPS) begin
            steps_reg = data[STEPS_W-1:0];
        end else if (idx == CFG_RAMP_INTERVAL) begin
            interval_reg = data;
        end
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] steps_data,
                                  input logic [CFG_DATA_W-1:0] interval_data);
        wait_until_quiet();
        write_reg(CFG_RAMP_STEPS, steps_data);
        write_reg(CFG_RAMP_INTERVAL, interval_data);
    endtask

    // One random sequence: mostly well-formed ramps and moves, some noise.
    task automatic run_episode();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            send_drive(pick_speed());
            repeat ($urandom_range(3, 40)) begin
                if ($urandom_range(0, 7) == 0) begin
                    send_drive(pick_speed());
                end
                send_tick(next_now(), $urandom_range(0, 19) != 0);
            end
            case ($urandom_range(0, 2))
                0: begin
                    send_stop();
                end
                1: begin
                    send_drive('0);
                    repeat ($urandom_range(5, 30)) send_tick(next_now(), 1'b1);
                end
                default: begin
                    send_tick(next_now(), 1'b0);
                end
            endcase
        end else if (kind < 7) begin
            send_move(pick_speed(), pick_count());
            repeat ($urandom_range(1, 6)) send_tick(next_now(), 1'b1);
            send_tick(next_now(), 1'b0);
        end else if (kind < 9) begin
            repeat ($urandom_range(1, 8)) begin
                send_item(make_item(t_mode'($urandom_range(0, 3)), $urandom,
                                    $urandom_range(0, 1), SPEED_W'($urandom),
                                    COUNT_W'($urandom)));
            end
        end else begin
            send_stop();
            send_tick(next_now(), $urandom_range(0, 1));
        end
    endtask

    // Idle stop strobe, reverse ramp, timer wrap and moves at reset settings.
    task automatic test_directed();
        send_tick(32'd0, 1'b1);
        send_drive(16'h8000);
        send_tick(32'd0, 1'b1);
        send_tick(32'd200, 1'b1);
        send_tick(32'd210, 1'b1);
        send_tick(32'd220, 1'b1);
        send_tick(32'hFFFF_FFF0, 1'b1);
        send_tick(32'h0000_0010, 1'b1);
        send_tick(32'h0000_0060, 1'b1);
        send_move(16'h8000, 24'h800000);
        send_tick(32'd300, 1'b0);
        send_tick(32'd301, 1'b1);
        send_move(16'h7FFF, 24'h7FFFFF);
        send_tick(32'd302, 1'b1);
        send_tick(32'd303, 1'b0);
        send_stop();
    endtask

    // Full-scale ramps in two steps, so that sums leave the 16-bit range.
    task automatic test_saturation();
        apply_settings(16'hA502, 16'h0000);
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        send_drive(16'h7FFF);
        repeat (4) send_tick(next_now(), 1'b1);
        send_drive(16'h8000);
        repeat (5) send_tick(next_now(), 1'b1);
    endtask

    // Random sequences under a range of register settings, extremes included.
    task automatic test_register_sweep();
        logic [CFG_DATA_W-1:0] steps_set [6];
        logic [CFG_DATA_W-1:0] interval_set [6];
        int goal;
        steps_set[0] = 16'h0000;
        interval_set[0] = 16'h0000;
        steps_set[1] = 16'h0001;
        interval_set[1] = 16'hFFFF;
        steps_set[2] = 16'hFFFF;
        interval_set[2] = 16'h0001;
        steps_set[3] = 16'h5A03;
        interval_set[3] = 16'h0005;
        steps_set[4] = CFG_DATA_W'(RAMP_STEPS_RST);
        interval_set[4] = RAMP_INTERVAL_RST;
        steps_set[5] = {8'($urandom), 8'($urandom_range(1, 6))};
        interval_set[5] = CFG_DATA_W'($urandom_range(0, 300));
        goal = items_sent;
        for (int s = 0; s < 6; s++) begin
            apply_settings(steps_set[s], interval_set[s]);
            goal += 200;
            while (items_sent < goal) run_episode();
        end
    endtask

    // Back-to-back traffic with no stalls on either side.
    task automatic test_steady_flow();
        int goal;
        apply_settings(CFG_DATA_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom_range(0, 20)));
        idling_on = 1'b0;
        goal = items_sent + 280;
        while (items_sent < goal) run_episode();
    endtask

    // Main sequence.
    initial begin
        ctl_phase = PH_IDLE;
        cur_speed = 0;
        set_speed = 0;
        step_or_pulses = 0;
        last_step_ms = '0;
        steps_reg = RAMP_STEPS_RST;
        interval_reg = RAMP_INTERVAL_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_saturation();
        test_register_sweep();
        test_steady_flow();
        wait_until_quiet();
        $display("Run covered %0d transactions, %0d commands checked, %0d register writes.",
                 items_sent, cmds_checked, reg_writes);
        $display("Commands carried %0d velocity writes, %0d move loads, %0d stop strobes.",
                 vel_writes, move_loads, stop_strobes);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Result-side stalls: short bursts, long calm stretches, none at the end.
    initial begin
        int r;
        forever begin
            r = $urandom_range(0, 19);
            if (idling_on && r < 4) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else if (r == 19) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compares every returned command with the oldest prediction.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (driver_cmd_q.size() == 0) begin
                $display("%0t: command with none pending, actual %h", $time, out_item);
                fail_count++;
            end else begin
                want = driver_cmd_q.pop_front();
                check_field("velocity_write", want.velocity_write, out_item.velocity_write);
                check_field("velocity_value", want.velocity_value, out_item.velocity_value);
                check_field("start_motor", want.start_motor, out_item.start_motor);
                check_field("stop_motor", want.stop_motor, out_item.stop_motor);
                check_field("move_load", want.move_load, out_item.move_load);
                check_field("move_pulses", want.move_pulses, out_item.move_pulses);
                check_field("phase", want.phase, out_item.phase);
                cmds_checked++;
            end
        end
    end

    // Watchdog on cycles without any transaction on any channel.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// File: sim.f
sv/msrc_pkg.sv
sv/msrc_div.sv
sv/motor_speed_ramp_controller.sv
verif/tb_top.sv
